// ----- hw/rtl/alid_pkg.sv -----
// alid_pkg: shared types and sizes for the array list block
// holds capacity, element width, command and result codes and cell select codes
// no dependencies
`timescale 1ns / 1ps

package alid_pkg;

    // list sizes
    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // port widths fixed by the interface
    localparam int MODE_W   = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int LEN_W    = 5;

    typedef logic [ELEM_W-1:0] elem_t;

    // command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // where a cell takes its next entry from
    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2,
        SEL_NEW   = 2'd3
    } cell_sel_t;

    // control handed to each cell
    typedef struct packed {
        cell_sel_t sel;
        logic      live;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/alid_cell.sv -----
// alid_cell: one list entry with its shift mux and search compare
// depends on alid_pkg
`timescale 1ns / 1ps

module alid_cell
    import alid_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  elem_t     left_data,
    input  elem_t     right_data,
    input  elem_t     new_data,
    input  elem_t     key,
    output elem_t     data,
    output logic      match
);

    elem_t entry_reg;
    elem_t entry_next;

    // pick the next entry from the neighbours or the incoming value
    always_comb
    begin
        case (ctl.sel)
            SEL_LEFT:  entry_next = left_data;
            SEL_RIGHT: entry_next = right_data;
            SEL_NEW:   entry_next = new_data;
            default:   entry_next = entry_reg;
        endcase
    end

    // entry storage, payload only
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // compare against the search key, only while the entry is in the list
    assign match = ctl.live && (entry_reg == key);
    assign data  = entry_reg;

endmodule

// ----- hw/rtl/alid_prio.sv -----
// alid_prio: lowest-index priority encoder over the registered match vector
// depends on alid_pkg
`timescale 1ns / 1ps

module alid_prio
    import alid_pkg::*;
(
    input  logic [CAPACITY-1:0] match,
    output logic                hit,
    output logic [IDX_W-1:0]    idx
);

    // scan from the top so the lowest matching cell wins
    always_comb
    begin
        idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                idx = IDX_W'(k);
            end
        end
    end

    assign hit = |match;

endmodule

// ----- hw/rtl/array_list_insert_delete_find.sv -----
// array_list_insert_delete_find: ordered list held in a row of shifting cells
// depends on alid_pkg, alid_cell, alid_prio
//
//   channel  | direction | handshake        | fields
//   ---------+-----------+------------------+-------------------------------
//   request  | in        | in_valid/in_stall   | mode, position, value
//   result   | out       | out_valid/out_stall | status, found_index, length
//
// a request is decoded in the cycle it is accepted: every cell shifts, loads
// or holds at that edge, and all cells compare against the search key at once
// the match vector is registered and a priority encoder finishes the find,
// so a result passes the first stage and then the output register; one request per cycle while in_stall is low
// stalls on the result side back up through the two stages to in_stall
// reset empties the list; cell contents are not cleared
`timescale 1ns / 1ps

module array_list_insert_delete_find
    import alid_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [MODE_W-1:0]          mode,
    input  logic [POS_W-1:0]           position,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [FIDX_W-1:0]          found_index,
    output logic [LEN_W-1:0]           length
);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_find_reg;
    status_t             s1_status_reg;
    logic [CNT_W-1:0]    s1_len_reg;
    logic [CAPACITY-1:0] s1_match_reg;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic [FIDX_W-1:0]   out_fidx_reg;
    logic [LEN_W-1:0]    out_len_reg;

    logic                accept;
    logic                s1_adv;
    logic                out_load;
    mode_t               cmd;
    elem_t               elem;
    int                  pos_int;
    int                  cnt_int;
    int                  slot;
    logic                ins_ok;
    logic                del_ok;
    status_t             status_now;
    cell_ctl_t           ctl      [CAPACITY];
    elem_t               cell_q   [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;

    // handshake between the stages
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign accept   = in_valid && !in_stall;

    // request decode
    assign cmd     = mode_t'(mode);
    assign elem    = ELEM_W'(value);
    assign pos_int = int'(position);
    assign cnt_int = int'(count_reg);
    assign slot    = pos_int - 1;

    always_comb
    begin
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        status_now = ST_OK;
        unique case (cmd)
            MODE_INSERT:
            begin
                if (cnt_int >= CAPACITY)
                    status_now = ST_FULL;
                else if (pos_int < 1 || pos_int > cnt_int + 1)
                    status_now = ST_BAD_POS;
                else
                    ins_ok = accept;
            end
            MODE_DELETE:
            begin
                if (pos_int < 1 || pos_int > cnt_int)
                    status_now = ST_BAD_POS;
                else
                    del_ok = accept;
            end
            default:
            begin
                status_now = ST_OK;
            end
        endcase
    end

    // next list length
    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
            count_next = count_reg + CNT_W'(1);
        else if (del_ok)
            count_next = count_reg - CNT_W'(1);
    end

    // row of cells
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        always_comb
        begin
            ctl[k].live = (k < cnt_int);
            ctl[k].sel  = SEL_HOLD;
            if (ins_ok)
            begin
                if (k == slot)
                    ctl[k].sel = SEL_NEW;
                else if (k > slot)
                    ctl[k].sel = SEL_LEFT;
            end
            else if (del_ok && k >= slot)
            begin
                ctl[k].sel = SEL_RIGHT;
            end
        end

        alid_cell u_cell (
            .clk        (clk),
            .ctl        (ctl[k]),
            .left_data  ((k == 0) ? cell_q[0] : cell_q[(k == 0) ? 0 : k - 1]),
            .right_data ((k == CAPACITY - 1) ? cell_q[k]
                                             : cell_q[(k == CAPACITY - 1) ? k : k + 1]),
            .new_data   (elem),
            .key        (elem),
            .data       (cell_q[k]),
            .match      (match_vec[k])
        );
    end

    // first stage control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // first stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_find_reg   <= (cmd == MODE_FIND);
            s1_status_reg <= status_now;
            s1_len_reg    <= count_next;
            s1_match_reg  <= match_vec;
        end
    end

    // first match over the registered compares
    alid_prio u_prio (
        .match (s1_match_reg),
        .hit   (hit),
        .idx   (hit_idx)
    );

    // output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_len_reg <= LEN_W'(s1_len_reg);
            if (s1_find_reg)
            begin
                out_status_reg <= hit ? ST_OK : ST_NOT_FOUND;
                out_fidx_reg   <= hit ? FIDX_W'(hit_idx) : '0;
            end
            else
            begin
                out_status_reg <= s1_status_reg;
                out_fidx_reg   <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_index = out_fidx_reg;
    assign length      = out_len_reg;

endmodule
